>>> rtl/limit_order_book_table_top_assert.svh
// Assertion macros used by the order book engine.
`ifndef LIMIT_ORDER_BOOK_TABLE_TOP_ASSERT_SVH
`define LIMIT_ORDER_BOOK_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define LOB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LOB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lob_pkg.sv
package lob_pkg;

    // command and result queue depth
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] order_id;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [4:0]  depth_levels;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        level_found;
        logic [31:0] level_price;
        logic [39:0] level_total;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_CANCEL,
        OP_MODIFY,
        OP_DEPTH
    } t_op;

    // classified command handed from front to engine
    typedef struct packed {
        t_op         op;
        logic [31:0] order_id;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [4:0]  want;
    } t_cmd;

endpackage

>>> rtl/lob_front.sv
module lob_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lob_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_clearing,
    output lob_pkg::t_cmd     o_cmd,
    output logic              o_cmd_empty,
    input  logic              i_cmd_pop
);
    import lob_pkg::*;

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int MAX_DEPTH_OUT = 16;
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_MODIFY = 2'd2;

    t_cmd           r_q [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    t_cmd           cls;
    logic           accept, take;

    // classify: decode function, clamp depth request
    always_comb begin
        cls.order_id = i_item.order_id;
        cls.side     = i_item.side;
        cls.price    = i_item.price;
        cls.quantity = i_item.quantity;
        cls.want     = (i_item.depth_levels > 5'(MAX_DEPTH_OUT)) ? 5'(MAX_DEPTH_OUT)
                                                                 : i_item.depth_levels;
        case (i_item.func)
            FUNC_ADD:    cls.op = OP_ADD;
            FUNC_CANCEL: cls.op = OP_CANCEL;
            FUNC_MODIFY: cls.op = OP_MODIFY;
            default:     cls.op = OP_DEPTH;
        endcase
    end

    assign o_full      = (r_cnt == (QAW+1)'(QDEPTH)) || i_clearing;
    assign o_cmd_empty = (r_cnt == '0);
    assign o_cmd       = r_q[r_rp];
    assign accept      = i_push && !o_full;
    assign take        = i_cmd_pop && !o_cmd_empty;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= cls;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_wp <= (r_wp == QAW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (take) begin
                r_rp <= (r_rp == QAW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(accept) - (QAW+1)'(take);
        end
    end

endmodule

>>> rtl/lob_resq.sv
module lob_resq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lob_pkg::t_out_item i_res,
    output logic               o_full,
    output lob_pkg::t_out_item o_res,
    output logic               o_empty,
    input  logic               i_pop
);
    import lob_pkg::*;

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_out_item      r_q [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           wr, rd;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_q[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_res;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == QAW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == QAW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(wr) - (QAW+1)'(rd);
        end
    end

endmodule

>>> rtl/lob_engine.sv
`include "limit_order_book_table_top_assert.svh"

module lob_engine #(
    parameter int MAX_ORDERS = 256,
    parameter int MAX_LEVELS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lob_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_pop,
    output logic               o_clearing,
    output logic               o_res_push,
    output lob_pkg::t_out_item o_res,
    input  logic               i_res_full
);
    import lob_pkg::*;

    localparam int SAW  = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int LAW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int MAXD = (MAX_ORDERS > MAX_LEVELS) ? MAX_ORDERS : MAX_LEVELS;
    localparam int IW   = $clog2(MAXD + 1);
    localparam logic [IW-1:0] SLOT_END = IW'(MAX_ORDERS);
    localparam logic [IW-1:0] LVL_END  = IW'(MAX_LEVELS);
    localparam logic [IW-1:0] CLR_LAST = IW'(MAXD - 1);
    localparam logic [39:0]   SUM_MAX  = '1;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_DUP     = 3'd1;
    localparam logic [2:0] STAT_ZERO    = 3'd2;
    localparam logic [2:0] STAT_UNKNOWN = 3'd3;
    localparam logic [2:0] STAT_FULL    = 3'd4;

    typedef struct packed {
        logic        used;
        logic [31:0] id;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
    } t_slot;

    typedef struct packed {
        logic        used;
        logic        side;
        logic [31:0] price;
        logic [39:0] sum;
    } t_level;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SSCAN, ST_DECIDE, ST_SCLR, ST_LSCAN_OLD, ST_OSCAN,
        ST_LUPD, ST_REMOVED, ST_LSCAN_NEW, ST_INSERT, ST_RESULT, ST_DSCAN,
        ST_DSTEP, ST_DLAST
    } t_state;

    // memories
    t_slot  r_slot_mem [MAX_ORDERS];
    t_level r_lvl_mem  [MAX_LEVELS];
    t_slot  r_slot_rd;
    t_level r_lvl_rd;

    t_state          r_state;
    t_cmd            r_cmd;
    logic [IW-1:0]   r_idx, r_chk_idx;
    logic            r_chk;
    logic [2:0]      r_status;
    logic            r_hit, r_free_ok;
    logic [SAW-1:0]  r_hit_idx, r_free_idx, r_tgt;
    logic [31:0]     r_old_price, r_old_qty;
    logic            r_old_side;
    logic            r_key_side;
    logic [31:0]     r_key_price;
    logic            r_lhit, r_lfree_ok;
    logic [LAW-1:0]  r_lhit_idx, r_lfree_idx;
    logic [39:0]     r_lhit_sum;
    logic            r_others;
    logic [4:0]      r_n;
    logic            r_have_prev, r_best_ok, r_pend_ok;
    logic [31:0]     r_prev, r_best_price, r_pend_price;
    logic [39:0]     r_best_sum, r_pend_sum;

    logic            slot_we, lvl_we;
    logic [SAW-1:0]  slot_waddr;
    logic [LAW-1:0]  lvl_waddr;
    t_slot           slot_wdata;
    t_level          lvl_wdata;
    logic            scanning, slot_scan, scan_issue, scan_done;
    logic [IW-1:0]   scan_end;
    logic [40:0]     add_full;
    logic [39:0]     sum_add, sum_sub;
    logic            lvl_key_hit, lvl_free, d_hit;
    t_out_item       res_pend;

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        r_slot_rd <= r_slot_mem[r_idx[SAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_lvl_mem[lvl_waddr] <= lvl_wdata;
        end
        r_lvl_rd <= r_lvl_mem[r_idx[LAW-1:0]];
    end

    // scan sequencing: one address issued per cycle, data checked in the cycle after
    always_comb begin
        scanning   = r_state inside {ST_SSCAN, ST_LSCAN_OLD, ST_OSCAN, ST_LSCAN_NEW, ST_DSCAN};
        slot_scan  = r_state inside {ST_SSCAN, ST_OSCAN};
        scan_end   = slot_scan ? SLOT_END : LVL_END;
        scan_issue = (r_idx != scan_end);
        scan_done  = !scan_issue && !r_chk;
    end

    always_comb begin
        add_full    = {1'b0, r_lhit_sum} + 41'(r_cmd.quantity);
        sum_add     = add_full[40] ? SUM_MAX : add_full[39:0];
        sum_sub     = (r_lhit_sum > 40'(r_old_qty)) ? r_lhit_sum - 40'(r_old_qty) : '0;
        lvl_key_hit = r_chk && r_lvl_rd.used && (r_lvl_rd.side == r_key_side)
                      && (r_lvl_rd.price == r_key_price);
        lvl_free    = r_chk && !r_lvl_rd.used;
        d_hit = r_chk && r_lvl_rd.used && (r_lvl_rd.side == r_cmd.side)
                && (!r_have_prev || (r_cmd.side ? (r_lvl_rd.price > r_prev)
                                                : (r_lvl_rd.price < r_prev)))
                && (!r_best_ok || (r_cmd.side ? (r_lvl_rd.price < r_best_price)
                                              : (r_lvl_rd.price > r_best_price)));
        res_pend = '{status: STAT_OK, level_found: 1'b1, level_price: r_pend_price,
                     level_total: r_pend_sum, last: 1'b0};
    end

    assign o_cmd_pop  = (r_state == ST_IDLE) && !i_cmd_empty;
    assign o_clearing = (r_state == ST_CLEAR);

    // memory writes and result pushes
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_hit_idx;
        slot_wdata = '0;
        lvl_we     = 1'b0;
        lvl_waddr  = r_lhit_idx;
        lvl_wdata  = '0;
        o_res_push = 1'b0;
        o_res      = '{status: r_status, level_found: 1'b0, level_price: '0,
                       level_total: '0, last: 1'b1};
        case (r_state)
            ST_CLEAR: begin
                slot_we    = (r_idx < SLOT_END);
                slot_waddr = r_idx[SAW-1:0];
                lvl_we     = (r_idx < LVL_END);
                lvl_waddr  = r_idx[LAW-1:0];
            end
            ST_SCLR: begin
                slot_we = 1'b1;
            end
            ST_LUPD: begin
                lvl_we    = 1'b1;
                lvl_wdata = '{used: r_others, side: r_key_side, price: r_key_price,
                              sum: sum_sub};
            end
            ST_INSERT: begin
                if (r_lhit || r_lfree_ok) begin
                    lvl_we     = 1'b1;
                    lvl_waddr  = r_lhit ? r_lhit_idx : r_lfree_idx;
                    lvl_wdata  = '{used: 1'b1, side: r_key_side, price: r_key_price,
                                   sum: r_lhit ? sum_add : 40'(r_cmd.quantity)};
                    slot_we    = 1'b1;
                    slot_waddr = r_tgt;
                    slot_wdata = '{used: 1'b1, id: r_cmd.order_id, side: r_key_side,
                                   price: r_key_price, qty: r_cmd.quantity};
                end
            end
            ST_RESULT: begin
                o_res_push = !i_res_full;
            end
            ST_DSTEP: begin
                if (!i_res_full) begin
                    if (!r_best_ok) begin
                        o_res_push = 1'b1;
                        if (r_pend_ok) begin
                            o_res      = res_pend;
                            o_res.last = 1'b1;
                        end
                    end else if (r_pend_ok) begin
                        o_res_push = 1'b1;
                        o_res      = res_pend;
                    end
                end
            end
            ST_DLAST: begin
                o_res_push = !i_res_full;
                o_res      = res_pend;
                o_res.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_chk   <= 1'b0;
        end else begin
            if (scanning) begin
                if (scan_issue) begin
                    r_idx     <= r_idx + 1'b1;
                    r_chk     <= 1'b1;
                    r_chk_idx <= r_idx;
                end else begin
                    r_chk <= 1'b0;
                end
            end
            case (r_state)
                ST_CLEAR: begin
                    if (r_idx == CLR_LAST) begin
                        r_idx   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd       <= i_cmd;
                        r_idx       <= '0;
                        r_chk       <= 1'b0;
                        r_hit       <= 1'b0;
                        r_free_ok   <= 1'b0;
                        r_pend_ok   <= 1'b0;
                        r_have_prev <= 1'b0;
                        r_best_ok   <= 1'b0;
                        r_n         <= '0;
                        r_status    <= STAT_OK;
                        if (i_cmd.op == OP_DEPTH) begin
                            r_state <= (i_cmd.want == '0) ? ST_RESULT : ST_DSCAN;
                        end else begin
                            r_state <= ST_SSCAN;
                        end
                    end
                end
                ST_SSCAN: begin
                    if (r_chk) begin
                        if (r_slot_rd.used && (r_slot_rd.id == r_cmd.order_id) && !r_hit) begin
                            r_hit       <= 1'b1;
                            r_hit_idx   <= r_chk_idx[SAW-1:0];
                            r_old_side  <= r_slot_rd.side;
                            r_old_price <= r_slot_rd.price;
                            r_old_qty   <= r_slot_rd.qty;
                        end
                        if (!r_slot_rd.used && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_chk_idx[SAW-1:0];
                        end
                    end
                    if (scan_done) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_idx      <= '0;
                    r_chk      <= 1'b0;
                    r_lhit     <= 1'b0;
                    r_lfree_ok <= 1'b0;
                    case (r_cmd.op)
                        OP_ADD: begin
                            if (r_hit) begin
                                r_status <= STAT_DUP;
                                r_state  <= ST_RESULT;
                            end else if (r_cmd.quantity == '0) begin
                                r_status <= STAT_ZERO;
                                r_state  <= ST_RESULT;
                            end else if (!r_free_ok) begin
                                r_status <= STAT_FULL;
                                r_state  <= ST_RESULT;
                            end else begin
                                r_key_side  <= r_cmd.side;
                                r_key_price <= r_cmd.price;
                                r_tgt       <= r_free_idx;
                                r_state     <= ST_LSCAN_NEW;
                            end
                        end
                        OP_CANCEL, OP_MODIFY: begin
                            if (!r_hit) begin
                                r_status <= STAT_UNKNOWN;
                                r_state  <= ST_RESULT;
                            end else if ((r_cmd.op == OP_MODIFY) && (r_cmd.quantity == '0)) begin
                                r_status <= STAT_ZERO;
                                r_state  <= ST_RESULT;
                            end else begin
                                r_key_side  <= r_old_side;
                                r_key_price <= r_old_price;
                                r_state     <= ST_SCLR;
                            end
                        end
                        default: r_state <= ST_IDLE;
                    endcase
                end
                ST_SCLR: begin
                    r_state <= ST_LSCAN_OLD;
                end
                ST_LSCAN_OLD, ST_LSCAN_NEW: begin
                    if (lvl_key_hit) begin
                        r_lhit     <= 1'b1;
                        r_lhit_idx <= r_chk_idx[LAW-1:0];
                        r_lhit_sum <= r_lvl_rd.sum;
                    end
                    if (lvl_free && !r_lfree_ok) begin
                        r_lfree_ok  <= 1'b1;
                        r_lfree_idx <= r_chk_idx[LAW-1:0];
                    end
                    if (scan_done) begin
                        if (r_state == ST_LSCAN_NEW) begin
                            r_state <= ST_INSERT;
                        end else if (r_lhit) begin
                            r_idx    <= '0;
                            r_others <= 1'b0;
                            r_state  <= ST_OSCAN;
                        end else begin
                            r_state <= ST_REMOVED;
                        end
                    end
                end
                ST_OSCAN: begin
                    if (r_chk && r_slot_rd.used && (r_slot_rd.side == r_key_side)
                        && (r_slot_rd.price == r_key_price)) begin
                        r_others <= 1'b1;
                    end
                    if (scan_done) begin
                        r_state <= ST_LUPD;
                    end
                end
                ST_LUPD: begin
                    r_state <= ST_REMOVED;
                end
                ST_REMOVED: begin
                    if (r_cmd.op == OP_MODIFY) begin
                        r_key_price <= r_cmd.price;
                        r_tgt       <= r_hit_idx;
                        r_lhit      <= 1'b0;
                        r_lfree_ok  <= 1'b0;
                        r_idx       <= '0;
                        r_chk       <= 1'b0;
                        r_state     <= ST_LSCAN_NEW;
                    end else begin
                        r_state <= ST_RESULT;
                    end
                end
                ST_INSERT: begin
                    r_status <= (r_lhit || r_lfree_ok) ? STAT_OK : STAT_FULL;
                    r_state  <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (!i_res_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_DSCAN: begin
                    if (d_hit) begin
                        r_best_ok    <= 1'b1;
                        r_best_price <= r_lvl_rd.price;
                        r_best_sum   <= r_lvl_rd.sum;
                    end
                    if (scan_done) begin
                        r_state <= ST_DSTEP;
                    end
                end
                ST_DSTEP: begin
                    if (!i_res_full) begin
                        if (!r_best_ok) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_pend_ok    <= 1'b1;
                            r_pend_price <= r_best_price;
                            r_pend_sum   <= r_best_sum;
                            r_prev       <= r_best_price;
                            r_have_prev  <= 1'b1;
                            r_n          <= r_n + 5'd1;
                            if (5'(r_n + 5'd1) == r_cmd.want) begin
                                r_state <= ST_DLAST;
                            end else begin
                                r_best_ok <= 1'b0;
                                r_idx     <= '0;
                                r_chk     <= 1'b0;
                                r_state   <= ST_DSCAN;
                            end
                        end
                    end
                end
                ST_DLAST: begin
                    if (!i_res_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `LOB_ASSERT_NOW(a_push_room, i_clk, i_rst_n, o_res_push, !i_res_full, "result pushed while full")
    `LOB_ASSERT_NOW(a_pop_idle, i_clk, i_rst_n, o_cmd_pop, (r_state == ST_IDLE) && !i_cmd_empty, "command taken outside idle")
    `LOB_ASSERT_NEXT(a_clear_end, i_clk, i_rst_n, (r_state == ST_CLEAR) && (r_idx == CLR_LAST), r_state == ST_IDLE, "clearing pass did not end")
    `LOB_ASSERT_NOW(a_depth_bound, i_clk, i_rst_n, r_state == ST_DSCAN, r_n < r_cmd.want, "depth walk past request")

endmodule

>>> rtl/limit_order_book_table_top.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+--------------------------------------
// command   | push in, full out    | i_item   (func, id, side, price, qty, depth)
// result    | pop in, empty out    | o_result (status, level, price, total, last)
//
// Command handling rests on the engine's linear scans over the order and level
// memories, one read port each, one entry per cycle. An accepted add scans the
// orders, then the levels; a cancel scans the orders, the levels and, if the
// level is found, the orders again; a modify also rescans the levels; a depth
// query scans the levels once per level walked.
// Reset: synchronous, active low; then a clearing pass over both memories with
// full held high.
// Stalls: a two-entry command queue and a two-entry result queue let each side
// stall on its own; the engine waits only when the result queue is full.
module limit_order_book_table_top #(
    parameter int MAX_ORDERS = 256,
    parameter int MAX_LEVELS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  lob_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output lob_pkg::t_out_item o_result
);
    import lob_pkg::*;

    t_cmd      cmd;
    logic      cmd_empty, cmd_pop, clearing;
    logic      res_push, res_full;
    t_out_item res;

    // front: accept transactions, decode and clamp, queue as commands
    lob_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_clearing  (clearing),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty),
        .i_cmd_pop   (cmd_pop)
    );

    // back: sequencer over the order and level memories
    lob_engine #(
        .MAX_ORDERS (MAX_ORDERS),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_clearing  (clearing),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    // result queue decouples engine from the consumer
    lob_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res),
        .o_full  (res_full),
        .o_res   (o_result),
        .o_empty (empty),
        .i_pop   (pop)
    );

endmodule

>>> dv/tb_limit_order_book_table_top.sv
module tb_limit_order_book_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lob_pkg::*;

    localparam int NUM_ORDERS = 256;
    localparam int NUM_LEVELS = 64;
    localparam int DEPTH_CAP = 16;
    localparam int NUM_ITEMS = 250;
    localparam logic [39:0] TOTAL_SAT = 40'hFF_FFFF_FFFF;

    // Result status codes.
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_DUP_ID = 3'd1;
    localparam logic [2:0] ST_ZERO_QTY = 3'd2;
    localparam logic [2:0] ST_UNKNOWN_ID = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    // Book predictor plus the store of expected results.
    class book_scoreboard;
        bit          ord_used[NUM_ORDERS];
        logic [31:0] ord_id[NUM_ORDERS];
        logic        ord_side[NUM_ORDERS];
        logic [31:0] ord_price[NUM_ORDERS];
        logic [31:0] ord_qty[NUM_ORDERS];
        bit          lv_used[NUM_LEVELS];
        logic        lv_side[NUM_LEVELS];
        logic [31:0] lv_price[NUM_LEVELS];
        logic [39:0] lv_total[NUM_LEVELS];
        t_out_item   pending_results[$];
        int          mismatches;
        int          results_seen;
        int          depth_rows;
        int          rejects;

        function int find_order(logic [31:0] id);
            for (int i = 0; i < NUM_ORDERS; i++)
                if (ord_used[i] && ord_id[i] == id) return i;
            return -1;
        endfunction

        function int find_level(logic side, logic [31:0] price);
            for (int i = 0; i < NUM_LEVELS; i++)
                if (lv_used[i] && lv_side[i] == side && lv_price[i] == price) return i;
            return -1;
        endfunction

        function int live_orders();
            int n;
            n = 0;
            foreach (ord_used[i]) n += ord_used[i];
            return n;
        endfunction

        function logic [2:0] insert_order(logic [31:0] id, logic side, logic [31:0] price,
                                          logic [31:0] qty);
            int s;
            int l;
            logic [40:0] sum;
            s = -1;
            for (int i = 0; i < NUM_ORDERS; i++)
                if (!ord_used[i] && s < 0) s = i;
            if (s < 0) return ST_FULL;
            l = find_level(side, price);
            if (l < 0) begin
                for (int i = 0; i < NUM_LEVELS; i++)
                    if (!lv_used[i] && l < 0) l = i;
                if (l < 0) return ST_FULL;
                lv_used[l] = 1;
                lv_side[l] = side;
                lv_price[l] = price;
                lv_total[l] = '0;
            end
            sum = lv_total[l] + qty;
            lv_total[l] = (sum > TOTAL_SAT) ? TOTAL_SAT : sum[39:0];
            ord_used[s] = 1;
            ord_id[s] = id;
            ord_side[s] = side;
            ord_price[s] = price;
            ord_qty[s] = qty;
            return ST_OK;
        endfunction

        function void remove_order(int s);
            int l;
            bit others;
            l = find_level(ord_side[s], ord_price[s]);
            others = 0;
            ord_used[s] = 0;
            if (l < 0) return;
            lv_total[l] = (lv_total[l] > ord_qty[s]) ? lv_total[l] - ord_qty[s] : '0;
            for (int i = 0; i < NUM_ORDERS; i++)
                if (ord_used[i] && ord_side[i] == ord_side[s] && ord_price[i] == ord_price[s])
                    others = 1;
            if (!others) lv_used[l] = 0;
        endfunction

        function void push_result(logic [2:0] st, logic found, logic [31:0] price,
                                  logic [39:0] total, logic last);
            t_out_item r;
            r.status = st;
            r.level_found = found;
            r.level_price = price;
            r.level_total = total;
            r.last = last;
            pending_results = {pending_results, r};
        endfunction

        // Note an accepted command transaction and predict its results.
        function void note_command(t_in_item c);
            int s;
            int want;
            int n;
            int best;
            bit have_prev;
            logic [31:0] prev;
            logic [2:0] st;
            st = ST_OK;
            prev = '0;
            case (t_op'(c.func))
                OP_ADD: begin
                    if (find_order(c.order_id) >= 0) st = ST_DUP_ID;
                    else if (c.quantity == 0) st = ST_ZERO_QTY;
                    else st = insert_order(c.order_id, c.side, c.price, c.quantity);
                end
                OP_CANCEL: begin
                    s = find_order(c.order_id);
                    if (s < 0) st = ST_UNKNOWN_ID;
                    else remove_order(s);
                end
                OP_MODIFY: begin
                    s = find_order(c.order_id);
                    if (s < 0) st = ST_UNKNOWN_ID;
                    else if (c.quantity == 0) st = ST_ZERO_QTY;
                    else begin
                        remove_order(s);
                        st = insert_order(c.order_id, ord_side[s], c.price, c.quantity);
                    end
                end
                default: begin
                    want = (c.depth_levels > DEPTH_CAP) ? DEPTH_CAP : int'(c.depth_levels);
                    n = 0;
                    have_prev = 0;
                    while (n < want) begin
                        best = -1;
                        for (int i = 0; i < NUM_LEVELS; i++) begin
                            if (!lv_used[i] || lv_side[i] != c.side) continue;
                            if (have_prev && (c.side == 1'b0 ? lv_price[i] >= prev
                                                             : lv_price[i] <= prev)) continue;
                            if (best < 0 || (c.side == 1'b0 ? lv_price[i] > lv_price[best]
                                                            : lv_price[i] < lv_price[best]))
                                best = i;
                        end
                        if (best < 0) break;
                        push_result(ST_OK, 1'b1, lv_price[best], lv_total[best], 1'b0);
                        prev = lv_price[best];
                        have_prev = 1;
                        n++;
                    end
                    depth_rows += n;
                    if (n == 0) push_result(ST_OK, 1'b0, '0, '0, 1'b1);
                    else pending_results[$].last = 1'b1;
                    return;
                end
            endcase
            if (st != ST_OK) rejects++;
            push_result(st, 1'b0, '0, '0, 1'b1);
        endfunction

        // Compare one accepted result transaction with the oldest expectation.
        function void check_result(t_out_item got);
            t_out_item exp;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %p", got);
                return;
            end
            exp = pending_results.pop_front();
            if (got.status !== exp.status || got.level_found !== exp.level_found ||
                got.level_price !== exp.level_price || got.level_total !== exp.level_total ||
                got.last !== exp.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected %p got %p", results_seen, exp, got);
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_result;

    book_scoreboard book;
    bit        stimulus_done;
    int        commands_sent;
    logic [31:0] id_pool[$];

    limit_order_book_table_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Send one command: present it at a falling edge and hold it until accepted.
    // push stays high afterwards; gaps and drains drop it.
    task automatic send_command(t_in_item c);
        push <= 1'b1;
        i_item <= c;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        book.note_command(c);
        commands_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_op(t_op op, logic [31:0] id, logic side, logic [31:0] price,
                           logic [31:0] qty, logic [4:0] lv);
        t_in_item c;
        c.func = op;
        c.order_id = id;
        c.side = side;
        c.price = price;
        c.quantity = qty;
        c.depth_levels = lv;
        send_command(c);
    endtask

    // Idle the sender for a number of cycles.
    task automatic pause_sender(int cycles);
        push <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Pause the sender until every expected result has come back.
    task automatic drain_results();
        push <= 1'b0;
        @(negedge i_clk);
        while (book.pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Mostly ids and prices from small pools so that cancels, modifies and
    // level sharing hit live entries; the rest are full-range noise.
    task automatic send_random_command();
        logic [31:0] id;
        logic [31:0] price;
        logic [31:0] qty;
        int pick;
        t_op op;
        pick = $urandom_range(99);
        op = (pick < 40) ? OP_ADD : (pick < 60) ? OP_CANCEL : (pick < 80) ? OP_MODIFY : OP_DEPTH;
        if ($urandom_range(9) == 0 || id_pool.size() == 0) id = $urandom();
        else id = id_pool[$urandom_range(id_pool.size() - 1)];
        if ($urandom_range(7) == 0) price = $urandom();
        else price = 32'd1000 + $urandom_range(40);
        case ($urandom_range(9))
            0: qty = '0;
            1: qty = 32'hFFFF_FFFF;
            2: qty = $urandom();
            default: qty = $urandom_range(1, 500);
        endcase
        if (op == OP_ADD && id_pool.size() < 64) id_pool = {id_pool, id};
        send_op(op, id, 1'($urandom_range(1)), price, qty, 5'($urandom_range(31)));
    endtask

    initial begin
        int burst;
        book = new();
        stimulus_done = 0;
        commands_sent = 0;
        push = 1'b0;
        pop = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every operation, each reject, extremes and depth cases.
        send_op(OP_DEPTH, 32'd0, 1'b0, '0, '0, 5'd4);            // empty bid side
        send_op(OP_ADD, 32'd0, 1'b0, 32'd100, 32'd10, 5'd0);
        send_op(OP_ADD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        send_op(OP_ADD, 32'd0, 1'b1, 32'd5, 32'd7, 5'd0);        // duplicate id
        send_op(OP_ADD, 32'd5, 1'b0, 32'd100, 32'd0, 5'd0);      // zero quantity
        send_op(OP_ADD, 32'd6, 1'b0, 32'd0, 32'd3, 5'd0);
        send_op(OP_ADD, 32'd7, 1'b0, 32'd100, 32'd4, 5'd0);      // shared level
        send_op(OP_ADD, 32'd8, 1'b1, 32'd0, 32'd9, 5'd0);
        send_op(OP_DEPTH, 32'd0, 1'b0, '0, '0, 5'd0);            // zero requested
        send_op(OP_DEPTH, 32'd0, 1'b0, '0, '0, 5'd31);           // clamped
        send_op(OP_DEPTH, 32'd0, 1'b1, '0, '0, 5'd16);
        send_op(OP_CANCEL, 32'd1234, 1'b0, '0, '0, 5'd0);        // unknown id
        send_op(OP_CANCEL, 32'd7, 1'b0, '0, '0, 5'd0);
        send_op(OP_MODIFY, 32'd999, 1'b0, 32'd1, 32'd1, 5'd0);   // unknown id
        send_op(OP_MODIFY, 32'd0, 1'b0, 32'd1, 32'd0, 5'd0);     // zero quantity
        send_op(OP_MODIFY, 32'd0, 1'b1, 32'd200, 32'd11, 5'd0);  // keeps bid side
        // Large level total: stack max quantities on one ask price.
        for (int i = 0; i < 4; i++)
            send_op(OP_ADD, 32'h100 + i, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
        send_op(OP_DEPTH, 32'd0, 1'b1, '0, '0, 5'd3);
        send_op(OP_CANCEL, 32'h100, 1'b0, '0, '0, 5'd0);          // subtract from a shared level
        send_op(OP_DEPTH, 32'd0, 1'b1, '0, '0, 5'd1);
        drain_results();

        // Fill every level on the bid side until the level store runs out.
        for (int i = 0; i < NUM_LEVELS + 2; i++)
            send_op(OP_ADD, 32'h2000 + i, 1'b0, 32'h5000 + i, 32'd1, 5'd0);
        send_op(OP_MODIFY, 32'h2000, 1'b0, 32'h7777, 32'd2, 5'd0); // re-add finds level
        send_op(OP_MODIFY, 32'd0, 1'b0, 32'h7778, 32'd2, 5'd0);
        send_op(OP_DEPTH, 32'd0, 1'b0, '0, '0, 5'd16);
        drain_results();
        // Clear the book back down.
        for (int i = 0; i < NUM_ORDERS; i++)
            if (book.ord_used[i]) send_op(OP_CANCEL, book.ord_id[i], 1'b0, '0, '0, 5'd0);
        drain_results();

        // Random bursts with random gaps; full drains in a window near the end.
        while (commands_sent < NUM_ITEMS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) send_random_command();
            if ($urandom_range(3) != 0) pause_sender($urandom_range(1, 20));
            if (commands_sent > NUM_ITEMS - 50 && commands_sent < NUM_ITEMS - 35)
                drain_results();
        end
        push <= 1'b0;
        stimulus_done = 1;
    end

    // Receiver: stalls on its own pattern, with long runs of always-ready.
    initial begin
        int cyc;
        cyc = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if ((cyc / 200) % 2 == 0) pop <= 1'b1;
            else pop <= ($urandom_range(3) != 0) && (cyc % 7 != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) book.check_result(o_result);
    end

    // End once everything is back, then keep watching for stray results.
    initial begin
        wait (stimulus_done);
        while (book.pending_results.size() != 0) @(posedge i_clk);
        repeat (4 * NUM_ORDERS) @(posedge i_clk);
        $display("Covered %0d commands, %0d results, %0d depth rows, %0d rejects.",
                 commands_sent, book.results_seen, book.depth_rows, book.rejects);
        if (book.mismatches == 0 && book.pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Mismatches: %0d", book.mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Timeout with %0d results outstanding", book.pending_results.size());
        $display("Test completed with failures");
        $finish;
    end
endmodule
